### hw/rtl/lfu_pkg.sv
// shared types and constants for the lfu cache table
package lfu_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int COUNT_BITS_DEF = 16;

    localparam int FIELD_W = 32;
    localparam int LIMIT_W = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_SET = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic match_found;
        logic victim_found;
        logic free_found;
    } t_scan_flags;

endpackage

### hw/rtl/lfu_cache_table.sv
// lfu cache table top level: sequencer, slot store, valid bits and result register
//
// usage:
//   s_axis carries one request: tuser is the action (0 get, 1 set), tdata holds
//   the key in bits 31:0 and the write value in bits 63:32.
//   m_axis carries one result per request: tuser bit 0 is hit, bit 1 is evicted;
//   tdata holds the read value in bits 31:0 (all ones on a miss or set) and the
//   evicted key in bits 63:32 (zero when nothing was evicted).
//   i_cfg_data sets the capacity limit; write it only while no request is open.
// sequence and throughput:
//   after accept the sequencer scans every slot from first to last:
//   the slot store has one read port, so the compare unit sees one slot a cycle,
//   then the last state drains the read and the finish state writes back and loads the result.
//   s_axis_tready is high only between requests, so a new request is accepted only
//   after the previous one has written back and loaded its result.
// reset:
//   all slots become empty and the capacity limit returns to 16.
// stall:
//   the result register holds while m_axis_tready is low; a following request is
//   accepted and scanned, then waits in its write back cycle until the register frees.
module lfu_cache_table #(
    parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [63:0]                 s_axis_tdata,   // lookup_key, write_value
    input  logic [0:0]                  s_axis_tuser,   // action
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [63:0]                 m_axis_tdata,   // read_value, evicted_key
    output logic [1:0]                  m_axis_tuser,   // hit, evicted
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lfu_pkg::LIMIT_W-1:0] i_cfg_data
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LIM_W  = (CNT_W > lfu_pkg::LIMIT_W) ? CNT_W : lfu_pkg::LIMIT_W;
    localparam int FW     = lfu_pkg::FIELD_W;
    localparam int WORD_W = KEY_BITS + FW + COUNT_BITS;

    lfu_pkg::t_state           r_state;
    lfu_pkg::t_state           n_state;
    logic [CNT_W-1:0]          r_addr;
    logic                      r_rd_step;
    logic [IDX_W-1:0]          r_rd_idx;
    logic [CAPACITY-1:0]       r_valid;
    logic [lfu_pkg::LIMIT_W-1:0] r_limit;
    logic                      r_action;
    logic [KEY_BITS-1:0]       r_key;
    logic [FW-1:0]             r_wval;
    logic                      r_out_valid;
    logic                      r_hit;
    logic [FW-1:0]             r_rval;
    logic                      r_ev;
    logic [FW-1:0]             r_evkey;

    logic                      rd_issue;
    logic                      scan_start;
    logic                      fin_go;
    logic [63:0]               key_ext;
    logic [63:0]               vkey_ext;

    logic [WORD_W-1:0]         ram_rdata;
    logic [WORD_W-1:0]         ram_wdata;
    logic [IDX_W-1:0]          ram_waddr;
    logic                      ram_we;

    lfu_pkg::t_scan_flags      scan_flags;
    logic [IDX_W-1:0]          match_idx;
    logic [FW-1:0]             match_value;
    logic [COUNT_BITS-1:0]     match_count;
    logic [IDX_W-1:0]          victim_idx;
    logic [KEY_BITS-1:0]       victim_key;
    logic [IDX_W-1:0]          free_idx;
    logic [CNT_W-1:0]          used;

    logic [LIM_W-1:0]          lim_eff;
    logic                      full;
    logic [COUNT_BITS-1:0]     cnt_inc;
    logic                      res_hit;
    logic [FW-1:0]             res_rval;
    logic                      res_ev;
    logic [FW-1:0]             res_evkey;
    logic                      ins;

    lfu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    lfu_scan #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (scan_start),
        .i_step        (r_rd_step),
        .i_idx         (r_rd_idx),
        .i_slot_valid  (r_valid[r_rd_idx]),
        .i_key         (r_key),
        .i_slot_key    (ram_rdata[WORD_W-1 -: KEY_BITS]),
        .i_slot_value  (ram_rdata[COUNT_BITS +: FW]),
        .i_slot_count  (ram_rdata[COUNT_BITS-1:0]),
        .o_flags       (scan_flags),
        .o_match_idx   (match_idx),
        .o_match_value (match_value),
        .o_match_count (match_count),
        .o_victim_idx  (victim_idx),
        .o_victim_key  (victim_key),
        .o_free_idx    (free_idx),
        .o_used        (used)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        rd_issue   = 1'b0;
        scan_start = 1'b0;
        fin_go     = 1'b0;
        unique case (r_state)
            lfu_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    scan_start = 1'b1;
                    n_state    = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN: begin
                rd_issue = 1'b1;
                if (r_addr == CNT_W'(CAPACITY - 1)) begin
                    n_state = lfu_pkg::ST_LAST;
                end
            end
            lfu_pkg::ST_LAST: begin
                n_state = lfu_pkg::ST_FINISH;
            end
            lfu_pkg::ST_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    fin_go  = 1'b1;
                    n_state = lfu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    // write back decision
    always_comb begin
        lim_eff = LIM_W'(r_limit);
        if (lim_eff == '0) begin
            lim_eff = LIM_W'(1);
        end
        if (lim_eff > LIM_W'(CAPACITY)) begin
            lim_eff = LIM_W'(CAPACITY);
        end
        full     = (LIM_W'(used) >= lim_eff);
        cnt_inc  = (match_count == '1) ? match_count : match_count + COUNT_BITS'(1);
        vkey_ext = 64'(victim_key);

        res_hit   = scan_flags.match_found;
        res_rval  = '1;
        res_ev    = 1'b0;
        res_evkey = '0;
        ins       = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = match_idx;
        ram_wdata = {r_key, r_wval, cnt_inc};

        if (scan_flags.match_found) begin
            ram_we = fin_go;
            if (r_action == lfu_pkg::ACT_GET) begin
                res_rval  = match_value;
                ram_wdata = {r_key, match_value, cnt_inc};
            end
        end else if (r_action == lfu_pkg::ACT_SET) begin
            ram_waddr = free_idx;
            if (full && scan_flags.victim_found) begin
                res_ev    = 1'b1;
                res_evkey = vkey_ext[FW-1:0];
                ram_waddr = victim_idx;
            end
            ins       = res_ev || scan_flags.free_found;
            ram_we    = fin_go && ins;
            ram_wdata = {r_key, r_wval, COUNT_BITS'(1)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_rd_step   <= 1'b0;
            r_valid     <= '0;
            r_limit     <= lfu_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_step <= rd_issue;
            if (scan_start) begin
                r_addr <= '0;
            end else if (rd_issue) begin
                r_addr <= r_addr + CNT_W'(1);
            end
            if (fin_go && ins) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign key_ext = {32'd0, s_axis_tdata[31:0]};

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr[IDX_W-1:0];
        if (scan_start) begin
            r_action <= s_axis_tuser[0];
            r_key    <= key_ext[KEY_BITS-1:0];
            r_wval   <= s_axis_tdata[63:32];
        end
        if (fin_go) begin
            r_hit   <= res_hit;
            r_rval  <= res_rval;
            r_ev    <= res_ev;
            r_evkey <= res_evkey;
        end
    end

    assign s_axis_tready = (r_state == lfu_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_evkey, r_rval};
    assign m_axis_tuser  = {r_ev, r_hit};

endmodule

### hw/rtl/lfu_ram.sv
// generic single write port ram with registered read
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/lfu_scan.sv
// shared compare unit: walks the slots for key match, lowest count and first free slot
module lfu_scan #(
    parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_start,
    input  logic                                          i_step,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] i_idx,
    input  logic                                          i_slot_valid,
    input  logic [KEY_BITS-1:0]                           i_key,
    input  logic [KEY_BITS-1:0]                           i_slot_key,
    input  logic [lfu_pkg::FIELD_W-1:0]                   i_slot_value,
    input  logic [COUNT_BITS-1:0]                         i_slot_count,
    output lfu_pkg::t_scan_flags                          o_flags,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] o_match_idx,
    output logic [lfu_pkg::FIELD_W-1:0]                   o_match_value,
    output logic [COUNT_BITS-1:0]                         o_match_count,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] o_victim_idx,
    output logic [KEY_BITS-1:0]                           o_victim_key,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] o_free_idx,
    output logic [$clog2(CAPACITY + 1)-1:0]               o_used
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    lfu_pkg::t_scan_flags            r_flags;
    logic [CNT_W-1:0]                r_used;
    logic [IDX_W-1:0]                r_match_idx;
    logic [lfu_pkg::FIELD_W-1:0]     r_match_value;
    logic [COUNT_BITS-1:0]           r_match_count;
    logic [IDX_W-1:0]                r_victim_idx;
    logic [KEY_BITS-1:0]             r_victim_key;
    logic [COUNT_BITS-1:0]           r_victim_count;
    logic [IDX_W-1:0]                r_free_idx;

    logic key_eq;
    logic cnt_lt;
    logic take_match;
    logic take_victim;
    logic take_free;

    always_comb begin
        key_eq      = (i_slot_key == i_key);
        cnt_lt      = (i_slot_count < r_victim_count);
        take_match  = i_step && i_slot_valid && !r_flags.match_found && key_eq;
        take_victim = i_step && i_slot_valid && (!r_flags.victim_found || cnt_lt);
        take_free   = i_step && !i_slot_valid && !r_flags.free_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_flags <= '0;
            r_used  <= '0;
        end else begin
            if (i_step && i_slot_valid) begin
                r_used <= r_used + CNT_W'(1);
            end
            if (take_match) begin
                r_flags.match_found <= 1'b1;
            end
            if (take_victim) begin
                r_flags.victim_found <= 1'b1;
            end
            if (take_free) begin
                r_flags.free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_match) begin
            r_match_idx   <= i_idx;
            r_match_value <= i_slot_value;
            r_match_count <= i_slot_count;
        end
        if (take_victim) begin
            r_victim_idx   <= i_idx;
            r_victim_key   <= i_slot_key;
            r_victim_count <= i_slot_count;
        end
        if (take_free) begin
            r_free_idx <= i_idx;
        end
    end

    assign o_flags       = r_flags;
    assign o_match_idx   = r_match_idx;
    assign o_match_value = r_match_value;
    assign o_match_count = r_match_count;
    assign o_victim_idx  = r_victim_idx;
    assign o_victim_key  = r_victim_key;
    assign o_free_idx    = r_free_idx;
    assign o_used        = r_used;

endmodule

### hw/rtl/lfu_chk.sv
// port level checks for the lfu cache table, bound to the top level
module lfu_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while busy");

    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[31:0] == 32'hFFFF_FFFF))
        else $error("miss without all ones value");

    a_evict_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> !m_axis_tuser[0])
        else $error("eviction on a hit");

    a_no_evict_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata[63:32] == 32'd0))
        else $error("evicted key without eviction");

endmodule

bind lfu_cache_table lfu_chk u_lfu_chk (.*);

### dv/tb_top.sv
`timescale 1ns / 1ps
// testbench for the lfu cache table: directed and random requests checked against a cache predictor
module tb_top;

    localparam int SLOTS        = lfu_pkg::CAPACITY_DEF;
    localparam int POOL_SIZE    = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;

    typedef struct packed {
        logic                        hit;
        logic [lfu_pkg::FIELD_W-1:0] read_value;
        logic                        evicted;
        logic [lfu_pkg::FIELD_W-1:0] evicted_key;
    } t_cache_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [63:0]                 s_axis_tdata;   // lookup_key, write_value
    logic [0:0]                  s_axis_tuser;   // action
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [63:0]                 m_axis_tdata;   // read_value, evicted_key
    logic [1:0]                  m_axis_tuser;   // hit, evicted
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [lfu_pkg::LIMIT_W-1:0] i_cfg_data;

    // predictor copy of the table
    logic                        tbl_valid [SLOTS];
    logic [31:0]                 tbl_key   [SLOTS];
    logic [31:0]                 tbl_value [SLOTS];
    logic [15:0]                 tbl_count [SLOTS];
    logic [lfu_pkg::LIMIT_W-1:0] tbl_limit = lfu_pkg::LIMIT_RESET;

    t_cache_result      pending_results[$];
    logic [31:0]        key_pool [POOL_SIZE];
    int                 mismatch_count = 0;
    int                 quiet_cycles = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    bit                 hold_request = 1'b0;

    lfu_cache_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_cache_result cache_access(input logic act, input logic [31:0] key,
                                                   input logic [31:0] wval);
        t_cache_result res;
        int lim;
        int used;
        int match;
        int victim;
        int free_slot;
        int dst;
        res = '{hit: 1'b0, read_value: '1, evicted: 1'b0, evicted_key: '0};
        lim = (tbl_limit < 1) ? 1 : ((tbl_limit > SLOTS) ? SLOTS : int'(tbl_limit));
        used = 0;
        match = -1;
        victim = -1;
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i]) begin
                used++;
                if (match < 0 && tbl_key[i] == key) match = i;
                if (victim < 0 || tbl_count[i] < tbl_count[victim]) victim = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (match >= 0) begin
            res.hit = 1'b1;
            if (tbl_count[match] != '1) tbl_count[match]++;
            if (act == lfu_pkg::ACT_GET) res.read_value = tbl_value[match];
            else tbl_value[match] = wval;
        end else if (act == lfu_pkg::ACT_SET) begin
            dst = free_slot;
            if (used >= lim && victim >= 0) begin
                res.evicted = 1'b1;
                res.evicted_key = tbl_key[victim];
                dst = victim;
            end
            if (dst >= 0) begin
                tbl_valid[dst] = 1'b1;
                tbl_key[dst] = key;
                tbl_value[dst] = wval;
                tbl_count[dst] = 16'd1;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (mismatch_count < 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
        mismatch_count++;
    endtask

    // sampled at the falling edge, so the values are those seen by the next rising edge
    always @(negedge i_clk) begin
        t_cache_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", '0, m_axis_tdata[31:0]);
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser[0] !== want.hit)
                        report_mismatch("hit", want.hit, m_axis_tuser[0]);
                    if (m_axis_tdata[31:0] !== want.read_value)
                        report_mismatch("read_value", want.read_value, m_axis_tdata[31:0]);
                    if (m_axis_tuser[1] !== want.evicted)
                        report_mismatch("evicted", want.evicted, m_axis_tuser[1]);
                    if (m_axis_tdata[63:32] !== want.evicted_key)
                        report_mismatch("evicted_key", want.evicted_key, m_axis_tdata[63:32]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(cache_access(s_axis_tuser[0], s_axis_tdata[31:0],
                                                       s_axis_tdata[63:32]));
            if (i_cfg_valid && o_cfg_ready) tbl_limit = i_cfg_data;
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("status: fail");
        $finish;
    end

    // receiver: random stalls, or one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    m_axis_tready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(input logic act, input logic [31:0] key, input logic [31:0] wval);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {wval, key};
        s_axis_tuser  <= act;
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [lfu_pkg::LIMIT_W-1:0] lim);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_and_basic();
        send_request(lfu_pkg::ACT_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(lfu_pkg::ACT_SET, 32'h0000_0000, 32'h7fff_ffff);
        send_request(lfu_pkg::ACT_SET, 32'hffff_ffff, 32'h8000_0000);
        send_request(lfu_pkg::ACT_GET, 32'hffff_ffff, 32'h1234_5678);
        send_request(lfu_pkg::ACT_SET, 32'h0000_0000, 32'hffff_ffff);
        send_request(lfu_pkg::ACT_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(lfu_pkg::ACT_GET, 32'h5a5a_5a5a, 32'hffff_ffff);
        wait_drained();
    endtask

    // limit of zero behaves as one, and lies below the current occupancy
    task automatic test_limit_floor();
        write_limit('0);
        send_request(lfu_pkg::ACT_SET, 32'h1234_5678, 32'h0000_0001);
        send_request(lfu_pkg::ACT_SET, 32'ha5a5_a5a5, 32'h0000_0002);
        send_request(lfu_pkg::ACT_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(lfu_pkg::ACT_GET, 32'ha5a5_a5a5, 32'h0000_0000);
        send_request(lfu_pkg::ACT_GET, 32'h1234_5678, 32'h0000_0000);
        wait_drained();
    endtask

    task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct,
                                    input logic [lfu_pkg::LIMIT_W-1:0] lim, input int window);
        logic        act;
        logic [31:0] key;
        write_limit(lim);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            act = $urandom_range(1) ? lfu_pkg::ACT_SET : lfu_pkg::ACT_GET;
            if ($urandom_range(99) < 12) key = $urandom();
            else key = key_pool[$urandom_range(window - 1)];
            send_request(act, key, $urandom());
        end
        wait_drained();
    endtask

    // the result side holds off while requests keep coming, then the sender waits for all
    task automatic test_backpressure();
        write_limit(5'd6);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        for (int n = 0; n < 8; n++)
            send_request(n[0] ? lfu_pkg::ACT_GET : lfu_pkg::ACT_SET, key_pool[n % 4],
                         $urandom());
        wait_drained();
    endtask

    task automatic test_random_mix();
        run_random_phase(91, 0, 0, 5'd31, 20);
        run_random_phase(91, 82, 0, 5'd16, 24);
        run_random_phase(91, 0, 82, 5'd4, 8);
        run_random_phase(91, 9, 9, 5'd1, 4);
        run_random_phase(91, 82, 0, lfu_pkg::LIMIT_W'($urandom_range(15, 2)), 24);
        run_random_phase(91, 0, 82, 5'd16, 12);
        run_random_phase(91, 9, 9, 5'd0, 3);
        run_random_phase(91, 0, 0, 5'd8, 24);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= lfu_pkg::ACT_GET;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= lfu_pkg::LIMIT_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_value[i] = '0;
            tbl_count[i] = '0;
        end
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hffff_ffff;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_basic();
        test_limit_floor();
        test_backpressure();
        test_random_mix();

        wait_drained();
        repeat (SLOTS + 8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
